[src/hrp_pkg.sv]
package hrp_pkg;

  typedef enum logic [1:0] {
    EV_DATA  = 2'd0,
    EV_EOF   = 2'd1,
    EV_FRAME = 2'd2
  } event_e;

  localparam logic [7:0] CharColon  = 8'h3A;
  localparam logic [7:0] DigitBase  = 8'h30;
  localparam logic [7:0] DigitMax   = 8'd9;
  localparam logic [7:0] AlphaGap   = 8'd7;
  localparam logic [1:0] TypeSkip   = 2'd2;
  localparam logic [1:0] TailSkip   = 2'd3;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = c - DigitBase;
    if (v > DigitMax) begin
      v = v - AlphaGap;
    end
    return v;
  endfunction

  function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo_char);
    logic [7:0] lo;
    lo = digit_value(lo_char);
    return {hi[3:0], 4'h0} | lo;
  endfunction

endpackage

[src/hex_record_parser.sv]
// A result is registered and shows on the output in the cycle after its character is accepted.
// Throughput: one character per cycle unless a held result stalls; the output register frees in
// the same cycle it is taken. Characters that cause no result simply update the record state.
// Reset (rst_ni low, asynchronous) returns to awaiting a start character with errors
// reported and clears the output register.
module hex_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_res_o,
  output logic [15:0] address_o,
  output logic [7:0]  data_o
);

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_LEN_HI = 4'd1,
    PH_LEN_LO = 4'd2,
    PH_AH_HI  = 4'd3,
    PH_AH_LO  = 4'd4,
    PH_AL_HI  = 4'd5,
    PH_AL_LO  = 4'd6,
    PH_TYPE   = 4'd7,
    PH_DAT_HI = 4'd8,
    PH_DAT_LO = 4'd9,
    PH_TAIL   = 4'd10
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  high_q, high_d;
  logic [7:0]  left_q, left_d;
  logic [15:0] addr_q, addr_d;
  logic [1:0]  skip_q, skip_d;
  logic        hunting_q, hunting_d;

  logic        out_valid_q;
  logic [1:0]  event_q;
  logic [15:0] out_addr_q;
  logic [7:0]  out_data_q;

  logic        emit;
  logic [1:0]  emit_event;
  logic [15:0] emit_addr;
  logic [7:0]  emit_data;
  logic [7:0]  pair;
  logic        accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pair       = hrp_pkg::pair_value(high_q, char_in_i);

  always_comb begin
    phase_d    = phase_q;
    high_d     = high_q;
    left_d     = left_q;
    addr_d     = addr_q;
    skip_d     = skip_q;
    hunting_d  = hunting_q;
    emit       = 1'b0;
    emit_event = hrp_pkg::EV_DATA;
    emit_addr  = '0;
    emit_data  = '0;
    unique case (phase_q)
      PH_LEN_HI, PH_AH_HI, PH_AL_HI, PH_DAT_HI: begin
        high_d  = hrp_pkg::digit_value(char_in_i);
        phase_d = phase_e'(phase_q + 4'd1);
      end
      PH_LEN_LO: begin
        left_d = pair;
        if (pair == 8'd0) begin
          hunting_d  = 1'b1;
          phase_d    = PH_START;
          emit       = 1'b1;
          emit_event = hrp_pkg::EV_EOF;
        end else begin
          phase_d = PH_AH_HI;
        end
      end
      PH_AH_LO: begin
        addr_d  = {pair, 8'h00};
        phase_d = PH_AL_HI;
      end
      PH_AL_LO: begin
        addr_d  = {addr_q[15:8], pair};
        skip_d  = hrp_pkg::TypeSkip;
        phase_d = PH_TYPE;
      end
      PH_TYPE: begin
        skip_d = skip_q - 2'd1;
        if (skip_q == 2'd1) begin
          phase_d = PH_DAT_HI;
        end
      end
      PH_DAT_LO: begin
        addr_d     = addr_q + 16'd1;
        left_d     = left_q - 8'd1;
        emit       = 1'b1;
        emit_event = hrp_pkg::EV_DATA;
        emit_addr  = addr_q;
        emit_data  = pair;
        if (left_q == 8'd1) begin
          skip_d  = hrp_pkg::TailSkip;
          phase_d = PH_TAIL;
        end else begin
          phase_d = PH_DAT_HI;
        end
      end
      PH_TAIL: begin
        skip_d = skip_q - 2'd1;
        if (skip_q == 2'd1) begin
          phase_d = PH_START;
        end
      end
      default: begin
        phase_d = PH_START;
        if (char_in_i == hrp_pkg::CharColon) begin
          hunting_d = 1'b0;
          phase_d   = PH_LEN_HI;
        end else if (!hunting_q) begin
          hunting_d  = 1'b1;
          emit       = 1'b1;
          emit_event = hrp_pkg::EV_FRAME;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      high_q      <= '0;
      left_q      <= '0;
      addr_q      <= '0;
      skip_q      <= '0;
      hunting_q   <= 1'b0;
      out_valid_q <= 1'b0;
      event_q     <= hrp_pkg::EV_DATA;
      out_addr_q  <= '0;
      out_data_q  <= '0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        phase_q   <= phase_d;
        high_q    <= high_d;
        left_q    <= left_d;
        addr_q    <= addr_d;
        skip_q    <= skip_d;
        hunting_q <= hunting_d;
        if (emit) begin
          out_valid_q <= 1'b1;
          event_q     <= emit_event;
          out_addr_q  <= emit_addr;
          out_data_q  <= emit_data;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_q;
  assign address_o   = out_addr_q;
  assign data_o      = out_data_q;

`ifndef SYNTH
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TYPE || phase_q == PH_TAIL) |-> skip_q != 2'd0)
    else $error("skip count is zero inside a skipped field");

  a_other_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && event_q != hrp_pkg::EV_DATA) |-> (out_addr_q == 16'd0 && out_data_q == 8'd0))
    else $error("non-data event carries address or data");

  a_eof_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit && emit_event == hrp_pkg::EV_EOF) |=> (phase_q == PH_START && hunting_q))
    else $error("end of file did not return to hunting");

  a_colon_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PH_START && char_in_i == hrp_pkg::CharColon)
      |=> (phase_q == PH_LEN_HI && !hunting_q))
    else $error("start character did not open a record");

  a_frame_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit && emit_event == hrp_pkg::EV_FRAME) |-> !hunting_q)
    else $error("framing error reported while hunting");
`endif

endmodule

[verif/hex_record_parser_checker.sv]
module hex_record_parser_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  char_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  event_res_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    AwaitStart,
    LenHi,
    LenLo,
    AddrHiHi,
    AddrHiLo,
    AddrLoHi,
    AddrLoLo,
    SkipType,
    DataHi,
    DataLo,
    SkipTail
  } rec_phase_e;

  typedef struct packed {
    hrp_pkg::event_e kind;
    logic [15:0]     addr;
    logic [7:0]      value;
  } parsed_event_t;

  parsed_event_t parsed_events_q[$];

  rec_phase_e  phase_q;
  logic [7:0]  high_nib_q;
  logic [7:0]  bytes_left_q;
  logic [15:0] cur_addr_q;
  logic [1:0]  skip_q;
  logic        hunting_q;

  function automatic logic [7:0] decode_digit(input logic [7:0] c);
    logic [7:0] v;
    v = c - hrp_pkg::DigitBase;
    if (v > hrp_pkg::DigitMax) begin
      v = v - hrp_pkg::AlphaGap;
    end
    return v;
  endfunction

  function automatic logic [7:0] join_pair(input logic [7:0] hi, input logic [7:0] c);
    logic [7:0] shifted;
    shifted = hi << 4;
    return shifted | decode_digit(c);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  task automatic parse_char(input logic [7:0] c);
    parsed_event_t ev;
    ev.kind  = hrp_pkg::EV_DATA;
    ev.addr  = '0;
    ev.value = '0;
    case (phase_q)
      LenHi, AddrHiHi, AddrLoHi, DataHi: begin
        high_nib_q = decode_digit(c);
        phase_q    = rec_phase_e'(phase_q + 4'd1);
      end
      LenLo: begin
        bytes_left_q = join_pair(high_nib_q, c);
        if (bytes_left_q == 8'd0) begin
          hunting_q = 1'b1;
          phase_q   = AwaitStart;
          ev.kind   = hrp_pkg::EV_EOF;
          parsed_events_q.push_back(ev);
        end else begin
          phase_q = AddrHiHi;
        end
      end
      AddrHiLo: begin
        cur_addr_q = {join_pair(high_nib_q, c), 8'h00};
        phase_q    = AddrLoHi;
      end
      AddrLoLo: begin
        cur_addr_q = cur_addr_q | {8'h00, join_pair(high_nib_q, c)};
        skip_q     = hrp_pkg::TypeSkip;
        phase_q    = SkipType;
      end
      SkipType: begin
        skip_q = skip_q - 2'd1;
        if (skip_q == 2'd0) begin
          phase_q = DataHi;
        end
      end
      DataLo: begin
        ev.addr      = cur_addr_q;
        ev.value     = join_pair(high_nib_q, c);
        parsed_events_q.push_back(ev);
        cur_addr_q   = cur_addr_q + 16'd1;
        bytes_left_q = bytes_left_q - 8'd1;
        if (bytes_left_q == 8'd0) begin
          skip_q  = hrp_pkg::TailSkip;
          phase_q = SkipTail;
        end else begin
          phase_q = DataHi;
        end
      end
      SkipTail: begin
        skip_q = skip_q - 2'd1;
        if (skip_q == 2'd0) begin
          phase_q = AwaitStart;
        end
      end
      default: begin
        phase_q = AwaitStart;
        if (c == hrp_pkg::CharColon) begin
          hunting_q = 1'b0;
          phase_q   = LenHi;
        end else if (!hunting_q) begin
          hunting_q = 1'b1;
          ev.kind   = hrp_pkg::EV_FRAME;
          parsed_events_q.push_back(ev);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    parsed_event_t exp_ev;
    if (!rst_ni) begin
      phase_q      = AwaitStart;
      high_nib_q   = '0;
      bytes_left_q = '0;
      cur_addr_q   = '0;
      skip_q       = '0;
      hunting_q    = 1'b0;
      parsed_events_q.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        parse_char(char_in_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (parsed_events_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result event %0d address %h data %h",
                                    event_res_i, address_i, data_i));
        end else begin
          exp_ev = parsed_events_q.pop_front();
          if (event_res_i !== exp_ev.kind) begin
            report_mismatch($sformatf("event %0d, expected %0d", event_res_i, exp_ev.kind));
          end
          if (address_i !== exp_ev.addr) begin
            report_mismatch($sformatf("address %h, expected %h", address_i, exp_ev.addr));
          end
          if (data_i !== exp_ev.value) begin
            report_mismatch($sformatf("data %h, expected %h", data_i, exp_ev.value));
          end
        end
      end
      pending_o <= parsed_events_q.size();
    end
  end

endmodule

[verif/hex_record_parser_tb.sv]
module hex_record_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 300000;
  localparam int PhaseChars   = 445;
  localparam int DrainCycles  = 8;
  localparam logic [7:0] Colon = 8'h3A;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  char_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  event_res_o;
  logic [15:0] address_o;
  logic [7:0]  data_o;

  int fail_count;
  int pending_events;
  int cycle_count = 0;
  int chars_sent;
  int send_idle_pct;
  int recv_stall_pct;

  logic [7:0] line_q[$];

  hex_record_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_in_i  (char_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .event_res_o(event_res_o),
    .address_o  (address_o),
    .data_o     (data_o)
  );

  hex_record_parser_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .char_in_i   (char_in_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_res_i (event_res_o),
    .address_i   (address_o),
    .data_i      (data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_events)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_char(input logic [7:0] c);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  function automatic logic [7:0] pick_char(input logic [3:0] n, input bit loose);
    if (loose && $urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
  endfunction

  task automatic queue_pair(input logic [7:0] b, input bit loose);
    line_q.push_back(pick_char(b[7:4], loose));
    line_q.push_back(pick_char(b[3:0], loose));
  endtask

  task automatic build_record(input bit end_of_file);
    int          len;
    int          tier;
    logic [15:0] base;
    line_q.delete();
    line_q.push_back(Colon);
    tier = $urandom_range(0, 99);
    if (end_of_file) begin
      len = 0;
    end else if (tier < 85) begin
      len = $urandom_range(1, 6);
    end else if (tier < 98) begin
      len = $urandom_range(7, 32);
    end else begin
      len = $urandom_range(128, 255);
    end
    base = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 6) == 0) begin
      base = 16'($urandom_range(16'hFFF0, 16'hFFFF));
    end
    queue_pair(8'(len), 1'b0);
    if (!end_of_file) begin
      queue_pair(base[15:8], 1'b1);
      queue_pair(base[7:0], 1'b1);
      line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < len; i++) begin
        queue_pair(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      line_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_line(input int count);
    for (int i = 0; i < count; i++) begin
      send_char(line_q[i]);
    end
  endtask

  task automatic run_random_stream(input int budget);
    int goal;
    int pick;
    goal = chars_sent + budget;
    while (chars_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        build_record(1'b0);
        send_line(line_q.size());
      end else if (pick < 85) begin
        build_record(1'b0);
        send_line($urandom_range(1, line_q.size() - 1));
      end else if (pick < 92) begin
        build_record(1'b1);
        send_line(line_q.size());
      end else begin
        repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    in_valid_i    <= 1'b0;
    char_in_i     <= 8'h00;
    rst_ni        <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    chars_sent     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two bytes across the address wrap, the first data pair holding a colon digit.
    send_text(":02FFFF00");
    send_text("A:00");
    send_text("\r\n.");
    // A bad start character reports once, then the hunt drops the rest.
    send_text("G");
    send_char(8'hFF);
    send_char(8'h00);
    send_text(":00");
    send_text("q");

    run_random_stream(PhaseChars);
    send_idle_pct = 71;
    run_random_stream(PhaseChars);
    send_idle_pct  = 0;
    recv_stall_pct = 71;
    run_random_stream(PhaseChars);
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    run_random_stream(PhaseChars);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending_events != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
